/* src/cartridge_bank_controller_defines.svh */
// Assertion macros shared by the cartridge bank controller RTL.
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

// cond must never hold while out of reset
`define CBC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// whenever ante holds, cons holds in the following cycle
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/cbc_pkg.sv */
// Types and constants of the cartridge bank controller.
package cbc_pkg;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_BANKS      = 4;
    localparam int RAM_DEPTH      = RAM_BANK_BYTES * RAM_BANKS;
    localparam int RAM_AW         = $clog2(RAM_DEPTH);
    localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int RAM_BANK_W     = $clog2(RAM_BANKS);
    localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_ROM_MASK = 2'd0;
    localparam logic [1:0] CFG_RAM_MASK = 2'd1;

    localparam logic [6:0] ROM_MASK_RST = 7'h7F;
    localparam logic [1:0] RAM_MASK_RST = 2'h3;

    // control write regions, address[14:13] below 0x8000
    localparam logic [1:0] REGION_RAM_EN = 2'd0;
    localparam logic [1:0] REGION_LOW    = 2'd1;
    localparam logic [1:0] REGION_UPPER  = 2'd2;
    localparam logic [1:0] REGION_MODE   = 2'd3;

    localparam logic [2:0] RAM_WINDOW = 3'b101;  // address[15:13] of 0xA000-0xBFFF
    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ROM,
        KIND_RAM_RD,
        KIND_RAM_WR
    } cbc_kind_t;

    typedef struct packed {
        cbc_kind_t         kind;
        logic [20:0]       rom_address;
        logic [RAM_AW-1:0] ram_index;
        logic [7:0]        wdata;
    } cbc_req_t;

endpackage

/* src/cbc_ram.sv */
// Generic single-port RAM with registered read.
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/cbc_front.sv */
// Front end: bank control registers, request classification and address translation.
module cbc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data,
    input  logic             accept,
    input  logic             func,
    input  logic [15:0]      address,
    input  logic [7:0]       write_data,
    output cbc_pkg::cbc_req_t req
);

    logic [6:0] rom_mask_reg, rom_mask_next;
    logic [1:0] ram_mask_reg, ram_mask_next;
    logic       ram_en_reg, ram_en_next;
    logic [4:0] low_bank_reg, low_bank_next;
    logic [1:0] upper_bank_reg, upper_bank_next;
    logic       mode_reg, mode_next;

    logic       in_ram_window;
    logic [6:0] rom_page;
    logic [1:0] ram_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_mask_reg   <= cbc_pkg::ROM_MASK_RST;
            ram_mask_reg   <= cbc_pkg::RAM_MASK_RST;
            ram_en_reg     <= 1'b0;
            low_bank_reg   <= 5'd1;
            upper_bank_reg <= 2'd0;
            mode_reg       <= 1'b0;
        end
        else
        begin
            rom_mask_reg   <= rom_mask_next;
            ram_mask_reg   <= ram_mask_next;
            ram_en_reg     <= ram_en_next;
            low_bank_reg   <= low_bank_next;
            upper_bank_reg <= upper_bank_next;
            mode_reg       <= mode_next;
        end
    end

    always_comb
    begin
        rom_mask_next = rom_mask_reg;
        ram_mask_next = ram_mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cbc_pkg::CFG_ROM_MASK: rom_mask_next = cfg_data;
                cbc_pkg::CFG_RAM_MASK: ram_mask_next = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign in_ram_window = (address[15:13] == cbc_pkg::RAM_WINDOW);

    // low window: bank 0, or the upper bank alone in mode 1; high window: upper and low banks; both masked
    always_comb
    begin
        if (address[14])
            rom_page = {upper_bank_reg, low_bank_reg};
        else if (mode_reg)
            rom_page = {upper_bank_reg, 5'd0};
        else
            rom_page = 7'd0;
        rom_page = rom_page & rom_mask_reg;
    end

    assign ram_page = mode_reg ? (upper_bank_reg & ram_mask_reg) : 2'd0;

    always_comb
    begin
        ram_en_next     = ram_en_reg;
        low_bank_next   = low_bank_reg;
        upper_bank_next = upper_bank_reg;
        mode_next       = mode_reg;

        req.kind        = cbc_pkg::KIND_NONE;
        req.rom_address = 21'd0;
        req.ram_index   = {ram_page[cbc_pkg::RAM_BANK_W-1:0],
                           address[cbc_pkg::RAM_OFS_W-1:0]};
        req.wdata       = write_data;

        if (func)
        begin
            if (!address[15])
            begin
                if (accept)
                begin
                    unique case (address[14:13])
                        cbc_pkg::REGION_RAM_EN:
                            ram_en_next = (write_data[3:0] == cbc_pkg::RAM_EN_KEY);
                        cbc_pkg::REGION_LOW:
                            low_bank_next = (write_data[4:0] == 5'd0) ? 5'd1
                                                                       : write_data[4:0];
                        cbc_pkg::REGION_UPPER:
                            upper_bank_next = write_data[1:0];
                        cbc_pkg::REGION_MODE:
                            mode_next = write_data[0];
                        default: ;
                    endcase
                end
            end
            else if (in_ram_window && ram_en_reg)
                req.kind = cbc_pkg::KIND_RAM_WR;
        end
        else
        begin
            if (!address[15])
            begin
                req.kind        = cbc_pkg::KIND_ROM;
                req.rom_address = {rom_page, address[cbc_pkg::ROM_OFS_W-1:0]};
            end
            else if (in_ram_window && ram_en_reg)
                req.kind = cbc_pkg::KIND_RAM_RD;
        end
    end

endmodule

/* src/cbc_queue.sv */
// Request queue between the front and back ends.
module cbc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cbc_pkg::cbc_req_t push_req,
    input  logic              pop,
    output cbc_pkg::cbc_req_t head,
    output logic              not_empty,
    output logic              full
);

    cbc_pkg::cbc_req_t entries [cbc_pkg::Q_DEPTH];

    logic [cbc_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cbc_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cbc_pkg::Q_AW:0]   count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_req;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    assign head      = entries[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (cbc_pkg::Q_AW + 1)'(cbc_pkg::Q_DEPTH));

endmodule

/* src/cbc_back.sv */
// Back end: cartridge RAM, its clearing pass after reset, and the result register.
`include "cartridge_bank_controller_defines.svh"

module cbc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cbc_pkg::cbc_req_t head,
    input  logic              q_not_empty,
    output logic              pop,
    output logic              clear_busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_data,
    output logic              rom_fetch,
    output logic [20:0]       rom_address,
    output logic              ram_access
);

    logic                      clear_busy_reg, clear_busy_next;
    logic [cbc_pkg::RAM_AW-1:0] clear_addr_reg, clear_addr_next;

    logic              s1_valid_reg, s1_valid_next;
    cbc_pkg::cbc_kind_t s1_kind_reg;
    logic [20:0]       s1_rom_addr_reg;

    logic                      ram_en;
    logic                      ram_we;
    logic [cbc_pkg::RAM_AW-1:0] ram_addr;
    logic [7:0]                ram_wdata;
    logic [7:0]                ram_rdata;
    logic                      head_is_ram;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_kind_reg     <= head.kind;
            s1_rom_addr_reg <= head.rom_address;
        end
    end

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == cbc_pkg::RAM_AW'(cbc_pkg::RAM_DEPTH - 1))
                clear_busy_next = 1'b0;
        end
    end

    assign pop = q_not_empty && !clear_busy_reg && (!s1_valid_reg || out_ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
            s1_valid_next = 1'b1;
        else if (out_ready)
            s1_valid_next = 1'b0;
    end

    assign head_is_ram = (head.kind == cbc_pkg::KIND_RAM_RD) ||
                         (head.kind == cbc_pkg::KIND_RAM_WR);

    // RAM reads only on a pop, so its output holds while the result is stalled
    assign ram_en    = clear_busy_reg || (pop && head_is_ram);
    assign ram_we    = clear_busy_reg || (head.kind == cbc_pkg::KIND_RAM_WR);
    assign ram_addr  = clear_busy_reg ? clear_addr_reg : head.ram_index;
    assign ram_wdata = clear_busy_reg ? 8'd0 : head.wdata;

    cbc_ram #(
        .WIDTH (8),
        .DEPTH (cbc_pkg::RAM_DEPTH)
    ) u_cart_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign clear_busy  = clear_busy_reg;
    assign out_valid   = s1_valid_reg;
    assign read_data   = (s1_kind_reg == cbc_pkg::KIND_RAM_RD) ? ram_rdata : 8'd0;
    assign rom_fetch   = (s1_kind_reg == cbc_pkg::KIND_ROM);
    assign rom_address = s1_rom_addr_reg;
    assign ram_access  = (s1_kind_reg == cbc_pkg::KIND_RAM_RD) ||
                         (s1_kind_reg == cbc_pkg::KIND_RAM_WR);

    `CBC_ASSERT_NEVER(a_no_pop_in_clear, pop && clear_busy_reg, "request popped during RAM clear")
    `CBC_ASSERT_NEXT(a_clear_once, !clear_busy_reg, !clear_busy_reg, "RAM clear restarted")
    `CBC_ASSERT_NEXT(a_rdata_hold, s1_valid_reg && !out_ready && s1_kind_reg == cbc_pkg::KIND_RAM_RD, $stable(ram_rdata), "RAM read data changed under a stalled result")
    `CBC_ASSERT_NEXT(a_stall_hold, s1_valid_reg && !out_ready, s1_valid_reg && $stable(s1_kind_reg), "stalled result lost")

endmodule

/* src/cartridge_bank_controller.sv */
// Cartridge bank controller top level: front end, request queue and back end.
//
// One bus access enters per request on the slave stream and yields exactly one result on the
// master stream, in order. Throughput is one request per clock once the RAM clear is done and
// while m_axis_tready is high; a request passes through the four-entry request queue and then
// the cartridge RAM read stage to its result. Bank control writes take effect for the very
// next request. After reset the 32768-byte cartridge RAM is cleared to zero, one byte per
// cycle, so s_axis_tready stays low until the clear is done; configuration writes are taken
// throughout. Configuration is meant to change only while no request is in flight.
module cartridge_bank_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_axis_tuser,   // [0] func (0 read, 1 write)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] read_data, [28:8] rom_address, zero fill
    output logic [1:0]  m_axis_tuser    // [0] rom_fetch, [1] ram_access
);

    cbc_pkg::cbc_req_t front_req;
    cbc_pkg::cbc_req_t q_head;
    logic              accept;
    logic              q_not_empty;
    logic              q_full;
    logic              pop;
    logic              clear_busy;
    logic [7:0]        read_data;
    logic              rom_fetch;
    logic [20:0]       rom_address;
    logic              ram_access;

    assign s_axis_tready = !q_full && !clear_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .func       (s_axis_tuser),
        .address    (s_axis_tdata[15:0]),
        .write_data (s_axis_tdata[23:16]),
        .req        (front_req)
    );

    cbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_req  (front_req),
        .pop       (pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    cbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .clear_busy  (clear_busy),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .read_data   (read_data),
        .rom_fetch   (rom_fetch),
        .rom_address (rom_address),
        .ram_access  (ram_access)
    );

    assign m_axis_tdata = {3'd0, rom_address, read_data};
    assign m_axis_tuser = {ram_access, rom_fetch};

endmodule
